// File: rtl/core/ugrw_pkg.sv
`default_nettype none

package ugrw_pkg;

	// Fixed-point and index widths.
	localparam int unsigned FX_W      = 32;
	localparam int unsigned IDX_W     = 9;
	localparam int unsigned RES_W     = 9;
	localparam int unsigned CELL_W    = 8;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned NUM_AXES  = 3;
	localparam int unsigned FRAC_W    = 16;

	// Largest grid resolution honored on any axis.
	localparam int unsigned MAX_RES = 256;

	typedef logic [FX_W-1:0]   fx_t;
	typedef logic [2*FX_W-1:0] prod_t;
	typedef logic [1:0]        axis_t;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RES_X       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RES_Y       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_RES_Z       = 3'd5;

	localparam fx_t              CELL_SIZE_RESET = 32'h0001_0000;
	localparam logic [RES_W-1:0] RES_RESET       = 9'd256;

	// Request modes.
	localparam logic MODE_START = 1'b0;
	localparam logic MODE_STEP  = 1'b1;

	// Axis of the smallest crossing, indexed by {n0<n1, n1<n2, n0<n2}.
	localparam axis_t AXIS_TABLE [8] = '{2'd2, 2'd0, 2'd1, 2'd1, 2'd2, 2'd0, 2'd0, 2'd0};

	// Status of the iterative divider.
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// Drop the fraction of a Q16.16 product and saturate it to 32 bits.
	function automatic fx_t sat_shift(input prod_t p);
		fx_t r;
		if (p[2*FX_W-1:FX_W+FRAC_W] != '0) begin
			r = '1;
		end else begin
			r = p[FX_W+FRAC_W-1:FRAC_W];
		end
		return r;
	endfunction

	// Resolution as used: zero counts as one, large values clamp to the maximum.
	function automatic logic [RES_W-1:0] eff_res(input logic [RES_W-1:0] r);
		logic [RES_W-1:0] e;
		if (r == '0) begin
			e = RES_W'(1);
		end else if (32'(r) > 32'(MAX_RES)) begin
			e = RES_W'(MAX_RES);
		end else begin
			e = r;
		end
		return e;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/ugrw_if.sv
`default_nettype none

interface ugrw_req_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [31:0] entry_x;
	logic [31:0] entry_y;
	logic [31:0] entry_z;
	logic signed [31:0] inv_dir_x;
	logic signed [31:0] inv_dir_y;
	logic signed [31:0] inv_dir_z;
	logic [31:0] range_limit;
	logic [31:0] closest_hit;

	modport source (
		output valid, mode, entry_x, entry_y, entry_z,
		output inv_dir_x, inv_dir_y, inv_dir_z, range_limit, closest_hit,
		input  ready
	);
	modport sink (
		input  valid, mode, entry_x, entry_y, entry_z,
		input  inv_dir_x, inv_dir_y, inv_dir_z, range_limit, closest_hit,
		output ready
	);
endinterface

interface ugrw_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] cell_x;
	logic [7:0] cell_y;
	logic [7:0] cell_z;
	logic       walk_done;

	modport source (
		output valid, cell_x, cell_y, cell_z, walk_done,
		input  ready
	);
	modport sink (
		input  valid, cell_x, cell_y, cell_z, walk_done,
		output ready
	);
endinterface

`default_nettype wire

// File: rtl/core/ugrw_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module ugrw_div (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire ugrw_pkg::fx_t    dividend,
	input  wire ugrw_pkg::fx_t    divisor,
	output ugrw_pkg::fx_t         quotient,
	output ugrw_pkg::fx_t         remainder,
	output ugrw_pkg::div_stat_t   stat
);
	import ugrw_pkg::*;

	localparam int unsigned CNT_W = $clog2(FX_W + 1);

	fx_t              rem_q;
	fx_t              quo_q;
	fx_t              dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [FX_W:0]    trial;

	// The partial remainder stays below twice the divisor, so bit FX_W flags a borrow.
	assign trial = {rem_q, quo_q[FX_W-1]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(FX_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[FX_W]) begin
				rem_q <= trial[FX_W-1:0];
				quo_q <= {quo_q[FX_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[FX_W-2:0], quo_q[FX_W-1]};
				quo_q <= {quo_q[FX_W-2:0], 1'b0};
			end
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

`default_nettype wire

// File: rtl/core/ugrw_mul.sv
`default_nettype none

// Registered 32 by 32 unsigned multiplier shared by all start-time products.
module ugrw_mul (
	input  wire logic          clk,
	input  wire ugrw_pkg::fx_t a,
	input  wire ugrw_pkg::fx_t b,
	output ugrw_pkg::prod_t    prod
);
	import ugrw_pkg::*;

	prod_t prod_q;

	always_ff @(posedge clk) begin
		prod_q <= prod_t'(a) * prod_t'(b);
	end

	assign prod = prod_q;

endmodule

`default_nettype wire

// File: rtl/core/uniform_grid_ray_walker.sv
`default_nettype none

// Three-dimensional DDA walker over a uniform voxel grid, Q16.16 fixed point.
// A start request (mode 0) carries the grid-relative entry point, the inverse
// direction and the range limit; the block answers with the first cell. Each
// step request (mode 1) carries the closest hit found so far; the block answers
// with the next cell, or with walk_done set when the next crossing lies beyond
// that hit, when the stepped crossing passes the range limit, or when the ray
// leaves the grid. Exactly one response follows every request. Cell fields read
// zero whenever walk_done is set, and a step with no active ray answers
// walk_done at once. Between acceptance of a step request and the next
// acceptance the block picks the axis, updates it and hands over the response.
// For a start request each of the three axes runs a restoring division of the
// entry coordinate by the cell size, then three passes through one shared
// 32 by 32 multiplier for the crossing delta, the clamped cell base and the
// first crossing. The response sits in an output register, so a new request
// is taken while the previous response still waits.
// The configuration registers are written through cfg_wr_en, cfg_index and
// cfg_wdata and should only change between requests.
module uniform_grid_ray_walker (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wr_en,
	input  wire logic [ugrw_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire ugrw_pkg::fx_t                     cfg_wdata,
	ugrw_req_if.sink                               req,
	ugrw_rsp_if.source                             rsp
);
	import ugrw_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE   = 11'b000_0000_0001,
		S_LOAD   = 11'b000_0000_0010,
		S_DIV    = 11'b000_0000_0100,
		S_MDELTA = 11'b000_0000_1000,
		S_MBASE  = 11'b000_0001_0000,
		S_MDIST  = 11'b000_0010_0000,
		S_MNEXT  = 11'b000_0100_0000,
		S_AXEND  = 11'b000_1000_0000,
		S_PICK   = 11'b001_0000_0000,
		S_UPD    = 11'b010_0000_0000,
		S_EMIT   = 11'b100_0000_0000
	} state_t;

	state_t state_q;

	// Configuration registers.
	fx_t              cs_q  [NUM_AXES];
	logic [RES_W-1:0] res_q [NUM_AXES];

	// Walk state.
	logic [IDX_W-1:0] cell_index_q  [NUM_AXES];
	fx_t              next_cross_q  [NUM_AXES];
	fx_t              cross_delta_q [NUM_AXES];
	logic             step_neg_q    [NUM_AXES];
	fx_t              limit_t_q;
	logic             walking_q;

	// Captured request fields.
	fx_t   entry_q [NUM_AXES];
	fx_t   inv_q   [NUM_AXES];
	fx_t   closest_q;
	axis_t ax_q;
	logic  sat_q;
	fx_t   d_q;
	logic  res_done_q;

	// Response register.
	logic             rsp_valid_q;
	logic [CELL_W-1:0] rsp_cell_q [NUM_AXES];
	logic             rsp_done_q;

	// Shared units.
	logic      div_start;
	fx_t       div_quo;
	fx_t       div_rem;
	div_stat_t div_stat;
	fx_t       mul_a;
	fx_t       mul_b;
	prod_t     mul_prod;

	// Per-axis views of the current axis.
	fx_t              cs_cur;
	fx_t              raw_cur;
	fx_t              mag_cur;
	logic             neg_cur;
	logic             dir_zero;
	logic [RES_W-1:0] res_cur;
	logic [RES_W-1:0] res_m1;
	logic             sat_div;
	fx_t              gap_cur;
	fx_t              base_lo;

	// Step datapath.
	logic [2:0]       pick_k;
	fx_t              nc_cur;
	logic [FX_W:0]    nc_sum;
	fx_t              nc_sat;
	logic [IDX_W-1:0] idx_cur;
	logic [IDX_W-1:0] idx_nxt;
	logic             leave;

	logic req_acc;
	logic out_free;

	assign req_acc   = req.valid && req.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE);
	assign div_start = (state_q == S_LOAD);

	always_comb begin
		cs_cur   = (cs_q[ax_q] == '0) ? fx_t'(1) : cs_q[ax_q];
		raw_cur  = inv_q[ax_q];
		neg_cur  = raw_cur[FX_W-1];
		dir_zero = (raw_cur == '0);
		// The most negative input keeps its bit pattern, which is also its magnitude.
		mag_cur  = neg_cur ? (~raw_cur + fx_t'(1)) : raw_cur;
		res_cur  = eff_res(res_q[ax_q]);
		res_m1   = res_cur - RES_W'(1);
		sat_div  = div_quo > {{(FX_W-RES_W){1'b0}}, res_m1};
		base_lo  = mul_prod[FX_W-1:0];
		// Distance to the first boundary. A clamped cell lies at or before the entry
		// point, so its upper boundary is already behind a positive ray.
		if (neg_cur) begin
			gap_cur = sat_q ? (entry_q[ax_q] - base_lo) : div_rem;
		end else begin
			gap_cur = sat_q ? '0 : (cs_cur - div_rem);
		end
	end

	always_comb begin
		case (state_q)
			S_MDELTA: begin
				mul_a = cs_cur;
				mul_b = mag_cur;
			end
			S_MBASE: begin
				mul_a = {{(FX_W-RES_W){1'b0}}, res_m1};
				mul_b = cs_cur;
			end
			S_MNEXT: begin
				mul_a = d_q;
				mul_b = mag_cur;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		pick_k  = {next_cross_q[0] < next_cross_q[1],
		           next_cross_q[1] < next_cross_q[2],
		           next_cross_q[0] < next_cross_q[2]};
		nc_cur  = next_cross_q[ax_q];
		nc_sum  = {1'b0, nc_cur} + {1'b0, cross_delta_q[ax_q]};
		nc_sat  = nc_sum[FX_W] ? '1 : nc_sum[FX_W-1:0];
		idx_cur = cell_index_q[ax_q];
		if (step_neg_q[ax_q]) begin
			leave   = (idx_cur == '0);
			idx_nxt = idx_cur - IDX_W'(1);
		end else begin
			leave   = ({1'b0, idx_cur} + (IDX_W+1)'(1)) >= {1'b0, res_cur};
			idx_nxt = idx_cur + IDX_W'(1);
		end
	end

	ugrw_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (entry_q[ax_q]),
		.divisor   (cs_cur),
		.quotient  (div_quo),
		.remainder (div_rem),
		.stat      (div_stat)
	);

	ugrw_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (mul_prod)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				cs_q[i]  <= CELL_SIZE_RESET;
				res_q[i] <= RES_RESET;
			end
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_CELL_SIZE_X: cs_q[0]  <= cfg_wdata;
				CFG_CELL_SIZE_Y: cs_q[1]  <= cfg_wdata;
				CFG_CELL_SIZE_Z: cs_q[2]  <= cfg_wdata;
				CFG_RES_X:       res_q[0] <= cfg_wdata[RES_W-1:0];
				CFG_RES_Y:       res_q[1] <= cfg_wdata[RES_W-1:0];
				CFG_RES_Z:       res_q[2] <= cfg_wdata[RES_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Request capture, no reset needed.
	always_ff @(posedge clk) begin
		if (req_acc) begin
			if (req.mode == MODE_START) begin
				entry_q[0] <= req.entry_x;
				entry_q[1] <= req.entry_y;
				entry_q[2] <= req.entry_z;
				inv_q[0]   <= req.inv_dir_x;
				inv_q[1]   <= req.inv_dir_y;
				inv_q[2]   <= req.inv_dir_z;
			end else begin
				closest_q <= req.closest_hit;
			end
		end
		if (state_q == S_DIV && div_stat.done) begin
			sat_q <= sat_div;
		end
		if (state_q == S_MDIST) begin
			d_q <= gap_cur;
		end
	end

	// Sequencer and walk state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			ax_q       <= '0;
			walking_q  <= 1'b0;
			limit_t_q  <= '0;
			res_done_q <= 1'b0;
			for (int i = 0; i < NUM_AXES; i++) begin
				cell_index_q[i]  <= '0;
				next_cross_q[i]  <= '1;
				cross_delta_q[i] <= '1;
				step_neg_q[i]    <= 1'b0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						if (req.mode == MODE_START) begin
							// A new ray drops any walk in progress.
							ax_q      <= '0;
							walking_q <= 1'b1;
							limit_t_q <= req.range_limit;
							state_q   <= S_LOAD;
						end else if (walking_q) begin
							state_q <= S_PICK;
						end else begin
							res_done_q <= 1'b1;
							state_q    <= S_EMIT;
						end
					end
				end
				S_LOAD: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_stat.done) begin
						cell_index_q[ax_q] <= sat_div ? res_m1 : div_quo[IDX_W-1:0];
						state_q            <= S_MDELTA;
					end
				end
				S_MDELTA: begin
					state_q <= S_MBASE;
				end
				S_MBASE: begin
					cross_delta_q[ax_q] <= dir_zero ? '1 : sat_shift(mul_prod);
					state_q             <= S_MDIST;
				end
				S_MDIST: begin
					state_q <= S_MNEXT;
				end
				S_MNEXT: begin
					state_q <= S_AXEND;
				end
				S_AXEND: begin
					// A parallel axis never crosses and counts as stepping negative.
					next_cross_q[ax_q] <= dir_zero ? '1 : sat_shift(mul_prod);
					step_neg_q[ax_q]   <= neg_cur || dir_zero;
					if (ax_q == axis_t'(NUM_AXES - 1)) begin
						res_done_q <= 1'b0;
						state_q    <= S_EMIT;
					end else begin
						ax_q    <= ax_q + axis_t'(1);
						state_q <= S_LOAD;
					end
				end
				S_PICK: begin
					ax_q    <= AXIS_TABLE[pick_k];
					state_q <= S_UPD;
				end
				S_UPD: begin
					if (nc_cur > closest_q) begin
						walking_q  <= 1'b0;
						res_done_q <= 1'b1;
					end else begin
						next_cross_q[ax_q] <= nc_sat;
						cell_index_q[ax_q] <= idx_nxt;
						if (nc_sat > limit_t_q || leave) begin
							walking_q  <= 1'b0;
							res_done_q <= 1'b1;
						end else begin
							res_done_q <= 1'b0;
						end
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_EMIT && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && out_free) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				rsp_cell_q[i] <= res_done_q ? '0 : cell_index_q[i][CELL_W-1:0];
			end
			rsp_done_q <= res_done_q;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.cell_x    = rsp_cell_q[0];
	assign rsp.cell_y    = rsp_cell_q[1];
	assign rsp.cell_z    = rsp_cell_q[2];
	assign rsp.walk_done = rsp_done_q;

	// A step request with no active ray goes straight to a finished response.
	a_idle_step_done: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && req.mode == MODE_STEP && !walking_q) |=>
			(state_q == S_EMIT && res_done_q))
		else $error("step without an active ray did not finish the walk");

	// A cell response is only ever produced while a ray is walking.
	a_cell_while_walking: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && !res_done_q) |-> walking_q)
		else $error("cell response without an active ray");

	// The divider only completes while the sequencer waits for it.
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == S_DIV))
		else $error("divider finished outside the division state");

	// A finished walk reports cleared cell fields.
	a_done_cells_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_done_q) |->
			(rsp_cell_q[0] == '0 && rsp_cell_q[1] == '0 && rsp_cell_q[2] == '0))
		else $error("finished walk reported a nonzero cell");

	// A new response is loaded only when the previous one has been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp.ready) |=> (rsp_valid_q && $stable(rsp_done_q)))
		else $error("pending response was overwritten");

endmodule

`default_nettype wire
